// ===== sv/assert_macros.svh =====
// Assertion helpers used by par_ctrl. They expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every rising clock edge outside reset.
`define PAR_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("check failed");

// Antecedent implies consequent in the same cycle.
`define PAR_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

`endif

// ===== sv/par_pkg.sv =====
`timescale 1ns / 1ps
package par_pkg;

  localparam int unsigned PEER_ENTRIES    = 128;
  localparam int unsigned ACCOUNT_ENTRIES = 256;
  localparam int unsigned WIN_SLOTS       = 64;
  localparam int unsigned TIME_W          = 48;
  localparam int unsigned KEY_W           = 64;
  localparam int unsigned FAIL_W          = 20;

  localparam int unsigned PIDX_W = $clog2(PEER_ENTRIES);
  localparam int unsigned AIDX_W = $clog2(ACCOUNT_ENTRIES);
  localparam int unsigned SIDX_W = (PIDX_W > AIDX_W) ? PIDX_W : AIDX_W;
  localparam int unsigned SLOT_W = $clog2(WIN_SLOTS);
  localparam int unsigned CNT_W  = SLOT_W + 1;
  localparam int unsigned PST_AW = 1 + PIDX_W + SLOT_W;
  localparam int unsigned GST_AW = 1 + SLOT_W;

  localparam logic [FAIL_W-1:0] FAIL_SAT = FAIL_W'(1000000);

  // action codes
  localparam logic [2:0] ACT_CONN   = 3'd0;
  localparam logic [2:0] ACT_CREATE = 3'd1;
  localparam logic [2:0] ACT_CHECK  = 3'd2;
  localparam logic [2:0] ACT_FAIL   = 3'd3;
  localparam logic [2:0] ACT_OK     = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_PEER_CONN     = 3'd0;
  localparam logic [2:0] CFG_GLOB_CONN     = 3'd1;
  localparam logic [2:0] CFG_CONN_WIN      = 3'd2;
  localparam logic [2:0] CFG_PEER_CREATE   = 3'd3;
  localparam logic [2:0] CFG_GLOB_CREATE   = 3'd4;
  localparam logic [2:0] CFG_CREATE_WIN    = 3'd5;
  localparam logic [2:0] CFG_ACCT_FAIL_LIM = 3'd6;
  localparam logic [2:0] CFG_ACCT_LOCK     = 3'd7;

  typedef struct packed {
    logic [6:0]  peer_conn_limit;
    logic [6:0]  global_conn_limit;
    logic [31:0] conn_window_ms;
    logic [6:0]  peer_create_limit;
    logic [6:0]  global_create_limit;
    logic [31:0] create_window_ms;
    logic [7:0]  account_fail_limit;
    logic [31:0] account_lock_ms;
  } cfg_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] seen;
    logic [CNT_W-1:0]  conn_cnt;
    logic [CNT_W-1:0]  create_cnt;
    logic [FAIL_W-1:0] fail;
    logic [TIME_W-1:0] blk;
  } peer_rec_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] seen;
    logic [FAIL_W-1:0] fail;
    logic [TIME_W-1:0] blk;
  } acct_rec_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic        allowed;
    logic [31:0] retry;
  } ctl_stat_t;

  function automatic logic [CNT_W-1:0] eff_limit(input logic [6:0] lim);
    logic [CNT_W-1:0] r;
    if (lim == 7'd0) begin
      r = CNT_W'(1);
    end else if ({25'd0, lim} > WIN_SLOTS) begin
      r = CNT_W'(WIN_SLOTS);
    end else begin
      r = CNT_W'(lim);
    end
    return r;
  endfunction

  // 1000 ms doubling from the third failure, capped at 60000 ms
  function automatic logic [15:0] backoff(input logic [FAIL_W-1:0] fails);
    logic [FAIL_W-1:0] sh;
    logic [15:0]       d;
    sh = fails - FAIL_W'(3);
    if (fails < FAIL_W'(3)) begin
      d = 16'd0;
    end else begin
      case (sh)
        FAIL_W'(0): d = 16'd1000;
        FAIL_W'(1): d = 16'd2000;
        FAIL_W'(2): d = 16'd4000;
        FAIL_W'(3): d = 16'd8000;
        FAIL_W'(4): d = 16'd16000;
        FAIL_W'(5): d = 16'd32000;
        default:    d = 16'd60000;
      endcase
    end
    return d;
  endfunction

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [31:0] d);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W-31){1'b0}}, d};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

// ===== sv/par_ram.sv =====
`timescale 1ns / 1ps
module par_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/par_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module par_ctrl import par_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              start,
  input  logic [2:0]        act_in,
  input  logic [KEY_W-1:0]  peer_in,
  input  logic [KEY_W-1:0]  acct_in,
  input  logic [TIME_W-1:0] now_in,
  input  logic              out_free,
  output ctl_stat_t         stat
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'h0001,
    S_PSCAN = 15'h0002,
    S_PRES  = 15'h0004,
    S_LINIT = 15'h0008,
    S_LRUN  = 15'h0010,
    S_LCHK  = 15'h0020,
    S_LAGE  = 15'h0040,
    S_LRET  = 15'h0080,
    S_ASCAN = 15'h0100,
    S_ARES  = 15'h0200,
    S_AUTH1 = 15'h0400,
    S_AUTH2 = 15'h0800,
    S_AUTH3 = 15'h1000,
    S_WB    = 15'h2000,
    S_FIN   = 15'h4000
  } state_t;

  state_t state_r, state_nxt;

  logic [2:0]        act_r;
  logic [KEY_W-1:0]  pkey_r, akey_r;
  logic [TIME_W-1:0] now_r;

  // slots are taken from zero up and never freed, so a fill count marks the valid ones
  logic [PIDX_W:0] pfill_r;
  logic [AIDX_W:0] afill_r;

  // table scan unit
  logic [SIDX_W:0]     sc_cnt_r;
  logic [SIDX_W-1:0]   sc_idx_r, hit_idx_r, emp_idx_r, old_idx_r;
  logic                sc_vld_r, hit_r, emp_r, old_have_r;
  logic [TIME_W-1:0]   old_seen_r;

  peer_rec_t         prec_r;
  acct_rec_t         arec_r;
  logic [PIDX_W-1:0] p_idx_r;
  logic [AIDX_W-1:0] a_idx_r;

  // sliding log unit
  logic              lg_glob_r, lg_vld_r;
  logic [CNT_W-1:0]  lg_n_r, lg_r_r, lg_w_r;
  logic [TIME_W-1:0] age_r;
  logic [CNT_W-1:0]  gcnt_conn_r, gcnt_crt_r;

  logic [TIME_W-1:0] pw_r, aw_r;
  logic              res_allow_r;
  logic [31:0]       res_retry_r;

  // memories
  peer_rec_t         p_rd;
  acct_rec_t         a_rd;
  logic [TIME_W-1:0] pst_rd, gst_rd;
  logic              p_we, a_we, pst_we, gst_we;
  logic [PST_AW-1:0] pst_raddr, pst_waddr;
  logic [GST_AW-1:0] gst_raddr, gst_waddr;
  logic [SLOT_W-1:0] slot_rd, slot_wr;
  logic [TIME_W-1:0] st_wdata;

  par_ram #(.WIDTH($bits(peer_rec_t)), .DEPTH(PEER_ENTRIES)) u_peer_tbl (
    .clk(clk), .we(p_we), .waddr(p_idx_r), .wdata(prec_r),
    .raddr(sc_cnt_r[PIDX_W-1:0]), .rdata(p_rd)
  );

  par_ram #(.WIDTH($bits(acct_rec_t)), .DEPTH(ACCOUNT_ENTRIES)) u_acct_tbl (
    .clk(clk), .we(a_we), .waddr(a_idx_r), .wdata(arec_r),
    .raddr(sc_cnt_r[AIDX_W-1:0]), .rdata(a_rd)
  );

  par_ram #(.WIDTH(TIME_W), .DEPTH(2 * PEER_ENTRIES * WIN_SLOTS)) u_peer_stamps (
    .clk(clk), .we(pst_we), .waddr(pst_waddr), .wdata(st_wdata),
    .raddr(pst_raddr), .rdata(pst_rd)
  );

  par_ram #(.WIDTH(TIME_W), .DEPTH(2 * WIN_SLOTS)) u_glob_stamps (
    .clk(clk), .we(gst_we), .waddr(gst_waddr), .wdata(st_wdata),
    .raddr(gst_raddr), .rdata(gst_rd)
  );

  // scan view of the current entry
  logic              scan_peer, sc_issue, sc_end_hit;
  logic [SIDX_W:0]   sc_end;
  logic              e_valid;
  logic [KEY_W-1:0]  e_key, m_key;
  logic [TIME_W-1:0] e_seen;
  peer_rec_t         p_hit, p_new;
  acct_rec_t         a_hit, a_new;
  logic [SIDX_W-1:0] miss_idx;

  always_comb begin
    scan_peer  = (state_r == S_PSCAN);
    sc_end     = scan_peer ? (SIDX_W+1)'(PEER_ENTRIES) : (SIDX_W+1)'(ACCOUNT_ENTRIES);
    sc_issue   = ((state_r == S_PSCAN) || (state_r == S_ASCAN)) && (sc_cnt_r < sc_end);
    sc_end_hit = (sc_cnt_r == sc_end) && !sc_vld_r;
    e_valid    = scan_peer ? ({1'b0, sc_idx_r[PIDX_W-1:0]} < pfill_r)
                           : ({1'b0, sc_idx_r[AIDX_W-1:0]} < afill_r);
    e_key      = scan_peer ? p_rd.key : a_rd.key;
    e_seen     = scan_peer ? p_rd.seen : a_rd.seen;
    m_key      = scan_peer ? pkey_r : akey_r;
    miss_idx   = emp_r ? emp_idx_r : old_idx_r;
    p_hit      = p_rd;
    p_hit.seen = now_r;
    a_hit      = a_rd;
    a_hit.seen = now_r;
    p_new      = '0;
    p_new.key  = pkey_r;
    p_new.seen = now_r;
    a_new      = '0;
    a_new.key  = akey_r;
    a_new.seen = now_r;
  end

  // log view
  logic              kind;
  logic [CNT_W-1:0]  lim;
  logic [31:0]       win;
  logic [TIME_W-1:0] st_rd, st_age;
  logic              keep, lg_full, lg_issue;

  always_comb begin
    kind = (act_r == ACT_CREATE);
    if (kind) begin
      lim = eff_limit(lg_glob_r ? cfg.global_create_limit : cfg.peer_create_limit);
      win = cfg.create_window_ms;
    end else begin
      lim = eff_limit(lg_glob_r ? cfg.global_conn_limit : cfg.peer_conn_limit);
      win = cfg.conn_window_ms;
    end
    st_rd    = lg_glob_r ? gst_rd : pst_rd;
    st_age   = now_r - st_rd;
    keep     = (now_r >= st_rd) && (st_age < {{(TIME_W-32){1'b0}}, win});
    lg_full  = (lg_w_r >= lim);
    lg_issue = (state_r == S_LRUN) && (lg_r_r < lg_n_r);
    slot_rd  = (state_r == S_LCHK) ? '0 : lg_r_r[SLOT_W-1:0];
    slot_wr  = lg_w_r[SLOT_W-1:0];
    pst_raddr = {kind, p_idx_r, slot_rd};
    pst_waddr = {kind, p_idx_r, slot_wr};
    gst_raddr = {kind, slot_rd};
    gst_waddr = {kind, slot_wr};
    st_wdata  = (state_r == S_LCHK) ? now_r : st_rd;
    pst_we = 1'b0;
    if ((state_r == S_LRUN) && lg_vld_r && keep) begin
      pst_we = 1'b1;
    end else if ((state_r == S_LCHK) && !lg_full) begin
      pst_we = 1'b1;
    end
    gst_we = pst_we && lg_glob_r;
    pst_we = pst_we && !lg_glob_r;
    p_we   = (state_r == S_WB);
    a_we   = (state_r == S_WB) && (act_r != ACT_CONN) && (act_r != ACT_CREATE);
  end

  logic act_known;
  assign act_known = (act_in <= ACT_OK);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = act_known ? S_PSCAN : S_FIN;
      S_PSCAN: if (sc_end_hit) state_nxt = S_PRES;
      S_PRES:  state_nxt = ((act_r == ACT_CONN) || (act_r == ACT_CREATE)) ? S_LINIT : S_ASCAN;
      S_LINIT: state_nxt = S_LRUN;
      S_LRUN:  if ((lg_r_r == lg_n_r) && !lg_vld_r) state_nxt = S_LCHK;
      S_LCHK:  state_nxt = lg_full ? S_LAGE : (lg_glob_r ? S_WB : S_LINIT);
      S_LAGE:  state_nxt = S_LRET;
      S_LRET:  state_nxt = S_WB;
      S_ASCAN: if (sc_end_hit) state_nxt = S_ARES;
      S_ARES:  state_nxt = S_AUTH1;
      S_AUTH1: state_nxt = (act_r == ACT_OK) ? S_WB : S_AUTH2;
      S_AUTH2: state_nxt = (act_r == ACT_CHECK) ? S_AUTH3 : S_WB;
      S_AUTH3: state_nxt = S_WB;
      S_WB:    state_nxt = S_FIN;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic [TIME_W-1:0] wmax;
  assign wmax = (pw_r > aw_r) ? pw_r : aw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pfill_r     <= '0;
      afill_r     <= '0;
      gcnt_conn_r <= '0;
      gcnt_crt_r  <= '0;
      sc_vld_r    <= 1'b0;
      lg_vld_r    <= 1'b0;
      lg_glob_r   <= 1'b0;
      sc_cnt_r    <= '0;
      lg_n_r      <= '0;
      lg_r_r      <= '0;
      lg_w_r      <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            act_r       <= act_in;
            pkey_r      <= peer_in;
            akey_r      <= acct_in;
            now_r       <= now_in;
            lg_glob_r   <= 1'b0;
            sc_cnt_r    <= '0;
            sc_vld_r    <= 1'b0;
            hit_r       <= 1'b0;
            emp_r       <= 1'b0;
            old_have_r  <= 1'b0;
            res_allow_r <= 1'b0;
            res_retry_r <= '0;
          end
        end
        S_PSCAN, S_ASCAN: begin
          sc_vld_r <= sc_issue;
          if (sc_issue) begin
            sc_idx_r <= sc_cnt_r[SIDX_W-1:0];
            sc_cnt_r <= sc_cnt_r + 1'b1;
          end
          if (sc_vld_r && !hit_r) begin
            if (!e_valid) begin
              if (!emp_r) begin
                emp_r     <= 1'b1;
                emp_idx_r <= sc_idx_r;
              end
            end else if (e_key == m_key) begin
              hit_r     <= 1'b1;
              hit_idx_r <= sc_idx_r;
              if (scan_peer) prec_r <= p_hit;
              else           arec_r <= a_hit;
            end else if (!old_have_r || (e_seen < old_seen_r)) begin
              old_have_r <= 1'b1;
              old_seen_r <= e_seen;
              old_idx_r  <= sc_idx_r;
            end
          end
        end
        S_PRES: begin
          if (hit_r) begin
            p_idx_r <= hit_idx_r[PIDX_W-1:0];
          end else begin
            p_idx_r <= miss_idx[PIDX_W-1:0];
            prec_r  <= p_new;
            if (emp_r) pfill_r <= pfill_r + 1'b1;
          end
          sc_cnt_r   <= '0;
          sc_vld_r   <= 1'b0;
          hit_r      <= 1'b0;
          emp_r      <= 1'b0;
          old_have_r <= 1'b0;
        end
        S_ARES: begin
          if (hit_r) begin
            a_idx_r <= hit_idx_r[AIDX_W-1:0];
          end else begin
            a_idx_r <= miss_idx[AIDX_W-1:0];
            arec_r  <= a_new;
            if (emp_r) afill_r <= afill_r + 1'b1;
          end
        end
        S_LINIT: begin
          if (lg_glob_r) lg_n_r <= kind ? gcnt_crt_r : gcnt_conn_r;
          else           lg_n_r <= kind ? prec_r.create_cnt : prec_r.conn_cnt;
          lg_r_r   <= '0;
          lg_w_r   <= '0;
          lg_vld_r <= 1'b0;
        end
        S_LRUN: begin
          lg_vld_r <= lg_issue;
          if (lg_issue) lg_r_r <= lg_r_r + 1'b1;
          // compact the survivors toward slot zero
          if (lg_vld_r && keep) lg_w_r <= lg_w_r + 1'b1;
        end
        S_LCHK: begin
          if (lg_glob_r) begin
            if (kind) gcnt_crt_r  <= lg_full ? lg_w_r : lg_w_r + 1'b1;
            else      gcnt_conn_r <= lg_full ? lg_w_r : lg_w_r + 1'b1;
          end else begin
            if (kind) prec_r.create_cnt <= lg_full ? lg_w_r : lg_w_r + 1'b1;
            else      prec_r.conn_cnt   <= lg_full ? lg_w_r : lg_w_r + 1'b1;
          end
          if (!lg_full) begin
            lg_glob_r <= 1'b1;
            if (lg_glob_r) begin
              res_allow_r <= 1'b1;
              res_retry_r <= '0;
            end
          end
        end
        S_LAGE: begin
          age_r <= (now_r >= st_rd) ? st_age : '0;
        end
        S_LRET: begin
          res_allow_r <= 1'b0;
          res_retry_r <= (age_r >= {{(TIME_W-32){1'b0}}, win}) ? 32'd0 : win - age_r[31:0];
        end
        S_AUTH1: begin
          case (act_r)
            ACT_CHECK: begin
              // drop blocks that have run out
              if ((prec_r.blk != '0) && (prec_r.blk <= now_r)) begin
                prec_r.fail <= '0;
                prec_r.blk  <= '0;
              end
              if ((arec_r.blk != '0) && (arec_r.blk <= now_r)) begin
                arec_r.fail <= '0;
                arec_r.blk  <= '0;
              end
            end
            ACT_FAIL: begin
              if (prec_r.fail < FAIL_SAT) prec_r.fail <= prec_r.fail + 1'b1;
              if (arec_r.fail < FAIL_SAT) arec_r.fail <= arec_r.fail + 1'b1;
            end
            default: begin
              prec_r.fail <= '0;
              prec_r.blk  <= '0;
              arec_r.fail <= '0;
              arec_r.blk  <= '0;
              res_allow_r <= 1'b1;
              res_retry_r <= '0;
            end
          endcase
        end
        S_AUTH2: begin
          if (act_r == ACT_CHECK) begin
            pw_r <= (prec_r.blk > now_r) ? prec_r.blk - now_r : '0;
            aw_r <= (arec_r.blk > now_r) ? arec_r.blk - now_r : '0;
          end else begin
            if (backoff(prec_r.fail) != 16'd0) begin
              prec_r.blk <= sat_add(now_r, {16'd0, backoff(prec_r.fail)});
            end
            if ((arec_r.fail >= {{(FAIL_W-8){1'b0}}, cfg.account_fail_limit}) &&
                (cfg.account_lock_ms != 32'd0)) begin
              arec_r.blk <= sat_add(now_r, cfg.account_lock_ms);
            end
            res_allow_r <= 1'b1;
            res_retry_r <= '0;
          end
        end
        S_AUTH3: begin
          res_allow_r <= (pw_r == '0) && (aw_r == '0);
          res_retry_r <= (wmax[TIME_W-1:32] != '0) ? 32'hFFFF_FFFF : wmax[31:0];
        end
        S_WB, S_FIN: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    stat.busy    = (state_r != S_IDLE);
    stat.done    = (state_r == S_FIN) && out_free;
    stat.allowed = res_allow_r;
    stat.retry   = res_retry_r;
  end

  `PAR_CHECK(a_lg_compact, lg_w_r <= lg_r_r)
  `PAR_CHECK(a_lg_depth, lg_n_r <= CNT_W'(WIN_SLOTS))
  `PAR_IMPLY(a_pscan_bound, state_r == S_PSCAN, sc_cnt_r <= (SIDX_W+1)'(PEER_ENTRIES))
  `PAR_CHECK(a_gcnt, (gcnt_conn_r <= CNT_W'(WIN_SLOTS)) && (gcnt_crt_r <= CNT_W'(WIN_SLOTS)))

endmodule

// ===== sv/peer_account_rate_limiter.sv =====
`timescale 1ns / 1ps
// Abuse-control rate limiter: one request at a time, one result per request.
// Every request with a known action code scans the peer table one entry per
// cycle through its single RAM read port; auth requests then scan the account
// table and do the block and counter update in states AUTH1 to AUTH3, as the
// action needs. Connection and creation requests instead walk the peer log and,
// if the peer log has room, then the global log, one stamp per cycle through
// the stamp RAM, with at most 64 stored stamps per log. in_stall is high while
// a request is being worked on; a finished result sits in the output register
// while the next is accepted.
module peer_account_rate_limiter import par_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_action,
  input  logic [KEY_W-1:0]  in_peer_id,
  input  logic [KEY_W-1:0]  in_account_id,
  input  logic [TIME_W-1:0] in_now_ms,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_allowed,
  output logic [31:0]       out_wait_ms,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_addr,
  input  logic [31:0]       cfg_wdata
);

  cfg_t      cfg_r;
  ctl_stat_t stat;
  logic      out_valid_r, out_allowed_r;
  logic [31:0] out_retry_r;
  logic      start, out_free;

  assign in_stall = stat.busy;
  assign start    = in_valid && !stat.busy;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.peer_conn_limit     <= 7'd5;
      cfg_r.global_conn_limit   <= 7'd30;
      cfg_r.conn_window_ms      <= 32'd10000;
      cfg_r.peer_create_limit   <= 7'd10;
      cfg_r.global_create_limit <= 7'd50;
      cfg_r.create_window_ms    <= 32'd600000;
      cfg_r.account_fail_limit  <= 8'd3;
      cfg_r.account_lock_ms     <= 32'd300000;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_PEER_CONN:     cfg_r.peer_conn_limit     <= cfg_wdata[6:0];
        CFG_GLOB_CONN:     cfg_r.global_conn_limit   <= cfg_wdata[6:0];
        CFG_CONN_WIN:      cfg_r.conn_window_ms      <= cfg_wdata;
        CFG_PEER_CREATE:   cfg_r.peer_create_limit   <= cfg_wdata[6:0];
        CFG_GLOB_CREATE:   cfg_r.global_create_limit <= cfg_wdata[6:0];
        CFG_CREATE_WIN:    cfg_r.create_window_ms    <= cfg_wdata;
        CFG_ACCT_FAIL_LIM: cfg_r.account_fail_limit  <= cfg_wdata[7:0];
        CFG_ACCT_LOCK:     cfg_r.account_lock_ms     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  par_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .start(start),
    .act_in(in_action), .peer_in(in_peer_id), .acct_in(in_account_id),
    .now_in(in_now_ms), .out_free(out_free), .stat(stat)
  );

  // hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      out_allowed_r <= stat.allowed;
      out_retry_r   <= stat.retry;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_allowed = out_allowed_r;
  assign out_wait_ms = out_retry_r;

endmodule
